// ===== design/abkf_pkg.sv =====
// Shared widths, register indexes and fixed point helpers for the angle/bias Kalman filter.
`default_nettype none
package abkf_pkg;
  localparam int W = 48;
  localparam int DT_BITS = 32;
  localparam logic signed [W-1:0] MAX48 = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN48 = {1'b1, {(W-1){1'b0}}};

  // register indexes
  localparam logic [2:0] REG_ANGLE_NOISE = 3'd0;
  localparam logic [2:0] REG_BIAS_NOISE  = 3'd1;
  localparam logic [2:0] REG_MEAS_NOISE  = 3'd2;
  localparam logic [2:0] REG_START_ANGLE = 3'd3;
  localparam logic [2:0] REG_START_BIAS  = 3'd4;

  // multiply request to the shared unit
  typedef struct packed {
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic [5:0]          sh;
  } mul_req_t;

  // saturating add/sub of two 48-bit values
  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s > $signed({1'b0, MAX48})) return MAX48;
    if (s < $signed({1'b1, MIN48})) return MIN48;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s > $signed({1'b0, MAX48})) return MAX48;
    if (s < $signed({1'b1, MIN48})) return MIN48;
    return s[W-1:0];
  endfunction

  // sign and 49-bit magnitude to saturated 48-bit
  function automatic logic signed [W-1:0] signed_sat(input logic neg,
                                                     input logic [W:0] m);
    if (neg) begin
      if (m >= {2'b01, {(W-1){1'b0}}}) return MIN48;
      return -$signed(m[W-1:0]);
    end
    if (m > {2'b00, {(W-1){1'b1}}}) return MAX48;
    return m[W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/abkf_mul.sv =====
// Shared multiplier: 48x48 magnitude product in 24-bit partial products, floor shift, saturate.
`default_nettype none
module abkf_mul
  import abkf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire mul_req_t            req,
  output logic                     done,
  output logic signed [W-1:0]      res
);
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r;
  logic        fin_r;
  logic        neg_r;
  logic [5:0]  sh_r;
  logic [W-1:0] ma_r, mb_r;
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [2*W-1:0] pp_sh;
  logic [2*W-1:0] shv;
  logic [2*W-1:0] rmask;
  logic          rem_nz;
  logic [W:0]    q;
  logic signed [W-1:0] res_r, res_nxt;

  // one 24x24 partial product per cycle: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    pa = step_r[1] ? ma_r[47:24] : ma_r[23:0];
    pb = step_r[0] ? mb_r[47:24] : mb_r[23:0];
    pp = pa * pb;
    pp_sh = {48'd0, pp} << (24 * (32'(step_r[1]) + 32'(step_r[0])));
  end

  // final shift and saturation
  always_comb begin
    shv = acc_r >> sh_r;
    rmask = ({{(2*W-1){1'b0}}, 1'b1} << sh_r) - 1'b1;
    rem_nz = |(acc_r & rmask);
    q = '0;
    if (|shv[2*W-1:W+1] || (shv[W:0] > {1'b1, {W{1'b0}}})) begin
      res_nxt = neg_r ? MIN48 : MAX48;
    end else begin
      q = shv[W:0] + {{W{1'b0}}, (neg_r && rem_nz)};
      res_nxt = signed_sat(neg_r, q);
    end
  end

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    if (busy_r) begin
      acc_nxt = acc_r + pp_sh;
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= start ? 2'd0 : step_nxt;
      busy_r <= start ? 1'b1 : busy_nxt;
      done_r <= busy_r && (step_r == 2'd3);
    end
    if (start) begin
      neg_r <= req.a[W-1] ^ req.b[W-1];
      ma_r  <= req.a[W-1] ? W'(-req.a) : W'(req.a);
      mb_r  <= req.b[W-1] ? W'(-req.b) : W'(req.b);
      sh_r  <= req.sh;
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // result registered in the cycle after the last accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else fin_r <= done_r;
    if (done_r) res_r <= res_nxt;
  end
  assign done = fin_r;
  assign res  = res_r;
endmodule
`default_nettype wire

// ===== design/abkf_div.sv =====
// Restoring divider: (num << FRAC_BITS) / den, one quotient bit per cycle, saturated.
`default_nettype none
module abkf_div
  import abkf_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] num,
  input  wire logic signed [W-1:0] den,
  output logic                     done,
  output logic signed [W-1:0]      quo
);
  localparam int NB = W + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r, neg_r, zero_r;
  logic [NB-1:0] sh_r;
  logic [W:0]    rem_r, ud_r;
  logic [W:0]    q_r;
  logic [W+1:0]  rtry;
  logic [W+1:0]  qtry;
  logic [W:0]    rnew, qnew;

  // one restoring step; quotient clamps at 2^48
  always_comb begin
    rtry = {rem_r, sh_r[NB-1]};
    qtry = {q_r, 1'b0};
    rnew = rtry[W:0];
    if (rtry >= {1'b0, ud_r}) begin
      rnew = (W+1)'(rtry - {1'b0, ud_r});
      qtry[0] = 1'b1;
    end
    if (qtry > {2'b01, {W{1'b0}}}) qnew = {1'b1, {W{1'b0}}};
    else qnew = qtry[W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      neg_r  <= num[W-1] ^ den[W-1];
      zero_r <= (den == '0);
      sh_r   <= {(num[W-1] ? W'(-num) : W'(num)), {FRAC_BITS{1'b0}}};
      ud_r   <= {1'b0, den[W-1] ? W'(-den) : W'(den)};
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= rnew;
      q_r   <= qnew;
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : signed_sat(neg_r, q_r);
endmodule
`default_nettype wire

// ===== design/angle_bias_kalman_filter.sv =====
// Top level: sequencer of the two-state angle/bias Kalman filter.
// Each input word goes through ten multiplies on the shared multiplier, two divides and three
// single steps before out_tvalid.
// A new word is taken only after the previous word has left the sequencer;
// in_tready is low while a word is in work, a waiting result only holds the next result.
// Reset (rst_n, synchronous): registers take their reset values, state reloads.
`default_nettype none
module angle_bias_kalman_filter
  import abkf_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [47:0] meas_angle, [95:48] gyro_rate, [127:96] step_time
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [47:0] filtered_angle
  output logic [47:0]       out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);
  // reset constants rounded at FRAC_BITS
  localparam longint ONE = 64'd1 << FRAC_BITS;
  localparam logic [W-1:0] R_AN = W'((ONE * 2 + 12) / 25);
  localparam logic [W-1:0] R_BN = W'((ONE * 3 + 500) / 1000);
  localparam logic [W-1:0] R_MN = W'((ONE * 11 + 10) / 20);
  localparam logic [W-1:0] R_SB = W'((ONE + 2) / 5);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0, S_RATE = 5'd1, S_M1 = 5'd2, S_M2 = 5'd3,
    S_M3 = 5'd4, S_M4 = 5'd5, S_M5 = 5'd6, S_S = 5'd7, S_D0 = 5'd8, S_D1 = 5'd9,
    S_M6 = 5'd10, S_M7 = 5'd11, S_M8 = 5'd12, S_M9 = 5'd13, S_M10 = 5'd14,
    S_OUT = 5'd16;

  logic [4:0] st_r;
  logic       wait_r;
  logic [W-2:0] an_r, bn_r, mn_r;
  logic signed [W-1:0] sa_r, sb_r;
  logic signed [W-1:0] ea_r, eb_r, paa_r, pab_r, pba_r, pbb_r;
  logic signed [W-1:0] meas_r, rate_r, dt_r, t_r, s_r, k0_r, k1_r, y_r, p00_r, p01_r;
  logic signed [W-1:0] dbb_r;
  logic       ov_r;
  logic [47:0] ov_data_r;

  mul_req_t mreq;
  logic mstart, mdone, dstart, ddone;
  logic signed [W-1:0] mres, dquo, dnum;

  abkf_mul u_mul (.clk, .rst_n, .start(mstart), .req(mreq), .done(mdone), .res(mres));
  abkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .rst_n, .start(dstart), .num(dnum),
    .den(s_r), .done(ddone), .quo(dquo));

  assign in_tready  = (st_r == S_IDLE);
  assign cfg_ready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = ov_data_r;

  // operand selection for the multiplier per state
  always_comb begin
    mreq.a = dt_r; mreq.b = pbb_r; mreq.sh = 6'(DT_BITS);
    dnum = paa_r;
    case (st_r)
      S_M1:  begin mreq.b = rate_r; end
      S_M2:  begin mreq.b = pbb_r; end
      S_M3:  begin mreq.b = t_r; end
      S_M4:  begin mreq.b = {1'b0, bn_r}; end
      S_M5:  begin mreq.a = k0_r; mreq.b = y_r; mreq.sh = 6'(FRAC_BITS); end
      S_M6:  begin mreq.a = k1_r; mreq.b = y_r; mreq.sh = 6'(FRAC_BITS); end
      S_M7:  begin mreq.a = k0_r; mreq.b = p00_r; mreq.sh = 6'(FRAC_BITS); end
      S_M8:  begin mreq.a = k0_r; mreq.b = p01_r; mreq.sh = 6'(FRAC_BITS); end
      S_M9:  begin mreq.a = k1_r; mreq.b = p00_r; mreq.sh = 6'(FRAC_BITS); end
      S_M10: begin mreq.a = k1_r; mreq.b = p01_r; mreq.sh = 6'(FRAC_BITS); end
      S_D1:  begin dnum = pba_r; end
      default: ;
    endcase
    mstart = !wait_r && (st_r == S_M1 || st_r == S_M2 || st_r == S_M3 || st_r == S_M4 ||
      st_r == S_M5 || st_r == S_M6 || st_r == S_M7 || st_r == S_M8 || st_r == S_M9 ||
      st_r == S_M10);
    dstart = !wait_r && (st_r == S_D0 || st_r == S_D1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wait_r <= 1'b0; ov_r <= 1'b0;
      an_r <= R_AN[W-2:0]; bn_r <= R_BN[W-2:0]; mn_r <= R_MN[W-2:0];
      sa_r <= '0; sb_r <= R_SB;
      ea_r <= '0; eb_r <= R_SB; paa_r <= '0; pab_r <= '0; pba_r <= '0; pbb_r <= '0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      // configuration writes, only between words
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANGLE_NOISE: an_r <= cfg_data[W-2:0];
          REG_BIAS_NOISE:  bn_r <= cfg_data[W-2:0];
          REG_MEAS_NOISE:  mn_r <= cfg_data[W-2:0];
          REG_START_ANGLE: begin
            sa_r <= cfg_data; ea_r <= cfg_data; eb_r <= sb_r;
            paa_r <= '0; pab_r <= '0; pba_r <= '0; pbb_r <= '0;
          end
          REG_START_BIAS: begin
            sb_r <= cfg_data; ea_r <= sa_r; eb_r <= cfg_data;
            paa_r <= '0; pab_r <= '0; pba_r <= '0; pbb_r <= '0;
          end
          default: ;
        endcase
      end
      if (mstart || dstart) wait_r <= 1'b1;
      case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          meas_r <= in_tdata[47:0]; rate_r <= in_tdata[95:48];
          dt_r <= {16'd0, in_tdata[127:96]};
          st_r <= S_RATE;
        end
        S_RATE: begin rate_r <= sub_s(rate_r, eb_r); st_r <= S_M1; end
        S_M1: if (mdone) begin
          wait_r <= 1'b0; ea_r <= add_s(ea_r, mres); st_r <= S_M2;
        end
        S_M2: if (mdone) begin
          wait_r <= 1'b0; dbb_r <= mres;
          t_r <= add_s(sub_s(sub_s(mres, pab_r), pba_r), {1'b0, an_r});
          st_r <= S_M3;
        end
        S_M3: if (mdone) begin
          wait_r <= 1'b0; paa_r <= add_s(paa_r, mres);
          pab_r <= sub_s(pab_r, dbb_r); pba_r <= sub_s(pba_r, dbb_r);
          st_r <= S_M4;
        end
        S_M4: if (mdone) begin
          wait_r <= 1'b0; pbb_r <= add_s(pbb_r, mres); st_r <= S_S;
        end
        S_S: begin
          s_r <= add_s(paa_r, {1'b0, mn_r}); y_r <= sub_s(meas_r, ea_r);
          p00_r <= paa_r; p01_r <= pab_r; st_r <= S_D0;
        end
        S_D0: if (ddone) begin wait_r <= 1'b0; k0_r <= dquo; st_r <= S_D1; end
        S_D1: if (ddone) begin wait_r <= 1'b0; k1_r <= dquo; st_r <= S_M5; end
        S_M5: if (mdone) begin wait_r <= 1'b0; ea_r <= add_s(ea_r, mres); st_r <= S_M6; end
        S_M6: if (mdone) begin wait_r <= 1'b0; eb_r <= add_s(eb_r, mres); st_r <= S_M7; end
        S_M7: if (mdone) begin wait_r <= 1'b0; paa_r <= sub_s(paa_r, mres); st_r <= S_M8; end
        S_M8: if (mdone) begin wait_r <= 1'b0; pab_r <= sub_s(pab_r, mres); st_r <= S_M9; end
        S_M9: if (mdone) begin wait_r <= 1'b0; pba_r <= sub_s(pba_r, mres); st_r <= S_M10; end
        S_M10: if (mdone) begin
          wait_r <= 1'b0; pbb_r <= sub_s(pbb_r, mres); st_r <= S_OUT;
        end
        S_OUT: if (!ov_r) begin
          ov_r <= 1'b1; ov_data_r <= ea_r; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/abkf_checker.sv =====
// Port-level checker for the angle/bias Kalman filter, bound to the top level.
`default_nettype none
module abkf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid) else $error("early result");
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid) else $error("result repeated");
endmodule

bind angle_bias_kalman_filter abkf_checker u_chk (.clk, .rst_n, .in_tvalid, .in_tready,
  .out_tvalid, .out_tready, .out_tdata);
`default_nettype wire
